// File: hw/rtl/vario_beep_tone_controller_defines.svh
// assertion macros shared by the tone controller files
`ifndef VARIO_BEEP_TONE_CONTROLLER_DEFINES_SVH
`define VARIO_BEEP_TONE_CONTROLLER_DEFINES_SVH

// checked property with reset masking
`define VBTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked property that also holds while in reset
`define VBTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/vbtc_pkg.sv
// ----------------------------------------------------------------------------
// vbtc_pkg
// Types, constants and the ramp table of the variometer beep tone controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vbtc_pkg;

  localparam int RAMP_ROWS  = 12;
  localparam int RAMP_IDX_W = $clog2(RAMP_ROWS);
  localparam int SPEED_W    = 12;
  localparam int COL_W      = 12;
  localparam int FREQ_W     = 11;
  localparam int VS_W       = 16;
  localparam int LVL_W      = 12;
  localparam int CNT_W      = 17;
  localparam int RATE_W     = 17;
  localparam int FRAC_SH    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // multiplier and divider widths
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
  localparam int SMS_W   = 27;
  localparam int SDUTY_W = 23;
  localparam int DIV_N_W = 44;
  localparam int DIV_D_W = 27;
  localparam int DIV_Q_W = 17;
  localparam int DIV_C_W = $clog2(DIV_Q_W + 1);

  // reciprocals for exact floor division of (x >> 16) by 1000 and by 100
  localparam int RCP_W      = 28;
  localparam int RCP_P_W    = 2 * RCP_W;
  localparam int CYC_RCP_SH = 37;
  localparam int ON_RCP_SH  = 31;
  // ceil(2^37 / 1000), exact for the whole 27-bit range of cycle products
  localparam logic [RCP_W-1:0] CYC_RECIP = 28'd137438954;
  // ceil(2^31 / 100), exact for the whole 24-bit range of on-length products
  localparam logic [RCP_W-1:0] ON_RECIP  = 28'd21474837;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIMB_ON    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIMB_OFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK        = 3'd3;

  // multiplier operand select
  localparam logic [2:0] MUL_FREQ = 3'd0;
  localparam logic [2:0] MUL_MS   = 3'd1;
  localparam logic [2:0] MUL_DUTY = 3'd2;
  localparam logic [2:0] MUL_CYC  = 3'd3;
  localparam logic [2:0] MUL_ON   = 3'd4;

  // ramp table: speed cm/s, frequency Hz, cycle ms, duty percent
  localparam logic signed [SPEED_W-1:0] RAMP_SPEED [RAMP_ROWS] = '{
    -12'sd1000, -12'sd300, -12'sd51, -12'sd50, 12'sd9, 12'sd10,
    12'sd116, 12'sd267, 12'sd424, 12'sd600, 12'sd800, 12'sd1000};
  localparam logic [COL_W-1:0] RAMP_FREQ [RAMP_ROWS] = '{
    12'd200, 12'd280, 12'd300, 12'd200, 12'd400, 12'd400,
    12'd550, 12'd763, 12'd985, 12'd1234, 12'd1517, 12'd1800};
  localparam logic [COL_W-1:0] RAMP_MS [RAMP_ROWS] = '{
    12'd100, 12'd100, 12'd500, 12'd800, 12'd600, 12'd600,
    12'd552, 12'd483, 12'd412, 12'd322, 12'd241, 12'd150};
  localparam logic [COL_W-1:0] RAMP_DUTY [RAMP_ROWS] = '{
    12'd100, 12'd100, 12'd100, 12'd5, 12'd10, 12'd50,
    12'd52, 12'd55, 12'd58, 12'd62, 12'd66, 12'd70};

  // controller to datapath commands
  typedef struct packed {
    logic       ld_in;
    logic       tick;
    logic       hyst;
    logic       div_start;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       wr_frac;
    logic       wr_freq;
    logic       wr_sms;
    logic       wr_sduty;
    logic       wr_cyc;
    logic       wr_on;
    logic       out_load;
  } vbtc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic due;
    logic en_next;
    logic interp;
    logic div_done;
    logic out_free;
  } vbtc_sts_t;

  // ramp speed of one row, sign extended to the speed input width
  function automatic logic signed [VS_W-1:0] spd_ext(input logic [RAMP_IDX_W-1:0] idx);
    logic signed [SPEED_W-1:0] s;
    s = RAMP_SPEED[idx];
    return VS_W'(s);
  endfunction

endpackage

// File: hw/rtl/vbtc_div.sv
// ----------------------------------------------------------------------------
// vbtc_div
// Restoring divider, one quotient bit per cycle, quotient known to fit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vario_beep_tone_controller_defines.svh"

module vbtc_div
  import vbtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] dividend_i,
  input  logic [DIV_D_W-1:0] divisor_i,
  output logic               done_o,
  output logic [DIV_Q_W-1:0] quotient_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DIV_C_W-1:0] cnt_q, cnt_d;
  logic [DIV_D_W:0]   rem_q, rem_d;
  logic [DIV_Q_W-1:0] num_q, num_d;
  logic [DIV_D_W-1:0] den_q, den_d;
  logic [DIV_Q_W-1:0] quo_q, quo_d;
  logic [DIV_D_W:0]   trial;
  logic               ge;

  // one shift and compare step
  assign trial = {rem_q[DIV_D_W-1:0], num_q[DIV_Q_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_C_W'(DIV_Q_W);
      rem_d  = (DIV_D_W + 1)'(dividend_i[DIV_N_W-1:DIV_Q_W]);
      num_d  = dividend_i[DIV_Q_W-1:0];
      den_d  = divisor_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? trial - {1'b0, den_q} : trial;
      quo_d = {quo_q[DIV_Q_W-2:0], ge};
      num_d = {num_q[DIV_Q_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_C_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `VBTC_ASSERT(a_div_done_after_busy, done_q |-> $past(busy_q), "divider done without a run")

endmodule

// File: hw/rtl/vbtc_dpath.sv
// ----------------------------------------------------------------------------
// vbtc_dpath
// Tone state, configuration, ramp lookup, shared multiplier and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vario_beep_tone_controller_defines.svh"

module vbtc_dpath
  import vbtc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vbtc_cmd_t             cmd_i,
  output vbtc_sts_t             sts_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic signed [VS_W-1:0] vertical_speed_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  gate_open_o,
  output logic [FREQ_W-1:0]     tone_frequency_o,
  output logic                  tone_active_o
);

  // configuration
  logic [RATE_W-1:0]       rate_q;
  logic signed [LVL_W-1:0] on_lvl_q, off_lvl_q, sink_q;

  // tone state
  logic              en_q;
  logic [CNT_W-1:0]  cnt_q, cycle_q, on_q;
  logic [FREQ_W-1:0] freq_q;

  // working registers
  logic signed [VS_W-1:0]  v_q;
  logic [RAMP_IDX_W-1:0]   lo_q, hi_q;
  logic [DIV_Q_W-1:0]      f_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SMS_W-1:0]        s_ms_q;
  logic [SDUTY_W-1:0]      s_duty_q;
  logic                    gate_q;

  // output register
  logic              ovalid_q;
  logic              ogate_q, oact_q;
  logic [FREQ_W-1:0] ofreq_q;

  logic [CNT_W-1:0]        cnt_inc;
  logic signed [VS_W-1:0]  on_x, off_x, sink_x;
  logic                    en_next;
  logic                    below, above;
  logic [RAMP_IDX_W-1:0]   seg_cnt;
  logic signed [VS_W-1:0]  num, den;
  logic [DIV_N_W-1:0]      div_n;
  logic [DIV_D_W-1:0]      div_d;
  logic                    div_done;
  logic [DIV_Q_W-1:0]      quo;
  logic [COL_W-1:0]        x0, x1;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic signed [PROD_W-1:0] base, prod_d;
  logic [RCP_W-1:0]        rcp_m;
  logic [RCP_P_W-1:0]      rcp_p;

  // period counter
  assign cnt_inc = cnt_q + 1'b1;

  // hysteresis
  assign on_x   = VS_W'(on_lvl_q);
  assign off_x  = VS_W'(off_lvl_q);
  assign sink_x = VS_W'(sink_q);
  always_comb begin
    en_next = en_q;
    if (en_q) begin
      if (v_q > sink_x && v_q < off_x) en_next = 1'b0;
    end else if (v_q < sink_x || v_q > on_x) begin
      en_next = 1'b1;
    end
  end

  // ramp segment search over the inner rows
  assign below = v_q < spd_ext(RAMP_IDX_W'(0));
  assign above = v_q >= spd_ext(RAMP_IDX_W'(RAMP_ROWS - 1));
  always_comb begin
    seg_cnt = '0;
    for (int j = 1; j < RAMP_ROWS - 1; j++) begin
      seg_cnt = seg_cnt + RAMP_IDX_W'(v_q >= spd_ext(RAMP_IDX_W'(j)));
    end
  end

  // divider operands: Q16 fraction of the speed within its segment
  assign num   = v_q - spd_ext(lo_q);
  assign den   = spd_ext(hi_q) - spd_ext(lo_q);
  assign div_n = DIV_N_W'({num, {FRAC_SH{1'b0}}});
  assign div_d = DIV_D_W'(den);

  vbtc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // shared multiplier operands: blends are x0 * 2^16 + (x1 - x0) * f
  always_comb begin
    x0    = '0;
    x1    = '0;
    mul_a = '0;
    mul_b = '0;
    base  = '0;
    case (cmd_i.mul_sel)
      MUL_FREQ, MUL_MS, MUL_DUTY: begin
        if (cmd_i.mul_sel == MUL_FREQ) begin
          x0 = RAMP_FREQ[lo_q];
          x1 = RAMP_FREQ[hi_q];
        end else if (cmd_i.mul_sel == MUL_MS) begin
          x0 = RAMP_MS[lo_q];
          x1 = RAMP_MS[hi_q];
        end else begin
          x0 = RAMP_DUTY[lo_q];
          x1 = RAMP_DUTY[hi_q];
        end
        mul_a = MUL_A_W'($signed({1'b0, x1}) - $signed({1'b0, x0}));
        mul_b = f_q;
        base  = PROD_W'({x0, {FRAC_SH{1'b0}}});
      end
      MUL_CYC: begin
        mul_a = MUL_A_W'(s_ms_q);
        mul_b = rate_q;
      end
      MUL_ON: begin
        mul_a = MUL_A_W'(s_duty_q);
        mul_b = cycle_q;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end
  assign prod_d = mul_a * $signed({1'b0, mul_b}) + base;

  // division by 1000 or 100 of the product above the fraction bits
  assign rcp_m = cmd_i.wr_cyc ? CYC_RECIP : ON_RECIP;
  assign rcp_p = prod_q[FRAC_SH +: RCP_W] * rcp_m;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= RATE_W'(48000);
      on_lvl_q  <= LVL_W'(10);
      off_lvl_q <= LVL_W'(5);
      sink_q    <= -LVL_W'(300);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SAMPLE_RATE: rate_q    <= cfg_data_i[RATE_W-1:0];
        CFG_CLIMB_ON:    on_lvl_q  <= cfg_data_i[LVL_W-1:0];
        CFG_CLIMB_OFF:   off_lvl_q <= cfg_data_i[LVL_W-1:0];
        CFG_SINK:        sink_q    <= cfg_data_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // tone state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      cnt_q   <= '0;
      cycle_q <= '0;
      on_q    <= '0;
      freq_q  <= '0;
    end else begin
      if (cmd_i.tick) cnt_q <= sts_o.due ? '0 : cnt_inc;
      if (cmd_i.hyst) begin
        en_q <= en_next;
        if (en_q && !en_next) begin
          cycle_q <= '0;
          on_q    <= '0;
        end
      end
      if (cmd_i.wr_freq) freq_q  <= prod_q[FRAC_SH +: FREQ_W];
      if (cmd_i.wr_cyc)  cycle_q <= rcp_p[CYC_RCP_SH +: CNT_W];
      if (cmd_i.wr_on)   on_q    <= rcp_p[ON_RCP_SH +: CNT_W];
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) v_q <= vertical_speed_i;
    if (cmd_i.tick) gate_q <= (cnt_q < on_q) && en_q;
    if (cmd_i.hyst) begin
      lo_q <= below ? '0 : (above ? RAMP_IDX_W'(RAMP_ROWS - 1) : seg_cnt);
      hi_q <= below ? '0 : (above ? RAMP_IDX_W'(RAMP_ROWS - 1) : seg_cnt + 1'b1);
      f_q  <= '0;
    end
    if (cmd_i.wr_frac)  f_q      <= quo;
    if (cmd_i.mul_en)   prod_q   <= prod_d;
    if (cmd_i.wr_sms)   s_ms_q   <= prod_q[SMS_W-1:0];
    if (cmd_i.wr_sduty) s_duty_q <= prod_q[SDUTY_W-1:0];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ogate_q <= gate_q;
      ofreq_q <= freq_q;
      oact_q  <= en_q;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign gate_open_o      = ogate_q;
  assign tone_frequency_o = ofreq_q;
  assign tone_active_o    = oact_q;

  assign sts_o.due      = cnt_inc >= cycle_q;
  assign sts_o.en_next  = en_next;
  assign sts_o.interp   = !(below || above);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !ovalid_q || !out_stall_i;

  `VBTC_ASSERT(a_cnt_in_cycle, (cnt_q < cycle_q) || (cnt_q == '0), "counter past cycle length")
  `VBTC_ASSERT(a_off_cleared, !en_q |-> (cycle_q == '0 && on_q == '0), "lengths kept while off")

endmodule

// File: hw/rtl/vbtc_ctrl.sv
// ----------------------------------------------------------------------------
// vbtc_ctrl
// Sequencer for one tick: count, hysteresis, interpolation, length update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vario_beep_tone_controller_defines.svh"

module vbtc_ctrl
  import vbtc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  vbtc_sts_t sts_i,
  output vbtc_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TICK  = 4'd1;
  localparam logic [3:0] S_HYST  = 4'd2;
  localparam logic [3:0] S_DIVF  = 4'd3;
  localparam logic [3:0] S_WAITF = 4'd4;
  localparam logic [3:0] S_MFREQ = 4'd5;
  localparam logic [3:0] S_MMS   = 4'd6;
  localparam logic [3:0] S_MDUTY = 4'd7;
  localparam logic [3:0] S_MCYC  = 4'd8;
  localparam logic [3:0] S_QCYC  = 4'd9;
  localparam logic [3:0] S_MON   = 4'd10;
  localparam logic [3:0] S_QON   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_TICK;
        end
      end
      S_TICK: begin
        cmd_o.tick = 1'b1;
        state_d    = sts_i.due ? S_HYST : S_OUT;
      end
      S_HYST: begin
        cmd_o.hyst = 1'b1;
        if (!sts_i.en_next) state_d = S_OUT;
        else if (sts_i.interp) state_d = S_DIVF;
        else state_d = S_MFREQ;
      end
      S_DIVF: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_WAITF;
      end
      S_WAITF: begin
        if (sts_i.div_done) begin
          cmd_o.wr_frac = 1'b1;
          state_d       = S_MFREQ;
        end
      end
      S_MFREQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_FREQ;
        state_d       = S_MMS;
      end
      S_MMS: begin
        cmd_o.wr_freq = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_MS;
        state_d       = S_MDUTY;
      end
      S_MDUTY: begin
        cmd_o.wr_sms  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DUTY;
        state_d       = S_MCYC;
      end
      S_MCYC: begin
        cmd_o.wr_sduty = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_CYC;
        state_d        = S_QCYC;
      end
      S_QCYC: begin
        cmd_o.wr_cyc = 1'b1;
        state_d      = S_MON;
      end
      S_MON: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ON;
        state_d       = S_QON;
      end
      S_QON: begin
        cmd_o.wr_on = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `VBTC_ASSERT(a_done_in_wait,
    sts_i.div_done |-> (state_q == S_WAITF),
    "divider result outside a wait state")

endmodule

// File: hw/rtl/vario_beep_tone_controller.sv
// ----------------------------------------------------------------------------
// vario_beep_tone_controller
// Variometer beep gate and tone frequency, one result per audio tick.
// ----------------------------------------------------------------------------
// channel | handshake               | payload
// in      | in_valid_i / in_stall_o | vertical_speed_i
// out     | out_valid_o / out_stall_i | gate_open_o, tone_frequency_o, tone_active_o
// cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// a tick with no tone update due only counts and then loads the output
// an interpolating update also runs the 17-step bit-serial divide for the
// ramp fraction; clamped ends skip it, switching off goes straight to output
// reset leaves the sample rate 48000 and thresholds 10, 5, -300 cm/s
// a stalled output holds the result; a new tick is taken once the block is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vario_beep_tone_controller
  import vbtc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [VS_W-1:0] vertical_speed_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   gate_open_o,
  output logic [FREQ_W-1:0]      tone_frequency_o,
  output logic                   tone_active_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  vbtc_cmd_t cmd;
  vbtc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  vbtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vbtc_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .vertical_speed_i (vertical_speed_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .gate_open_o      (gate_open_o),
    .tone_frequency_o (tone_frequency_o),
    .tone_active_o    (tone_active_o)
  );

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives speed ticks into the beep tone controller, predicts gate, frequency
// and hysteresis state for every tick and compares each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import vbtc_pkg::*;

  // ramp table as integers for the predictor
  localparam int RSPD [12] = '{-1000, -300, -51, -50, 9, 10, 116, 267, 424, 600, 800, 1000};
  localparam int RFRQ [12] = '{200, 280, 300, 200, 400, 400, 550, 763, 985, 1234, 1517, 1800};
  localparam int RMS  [12] = '{100, 100, 500, 800, 600, 600, 552, 483, 412, 322, 241, 150};
  localparam int RDTY [12] = '{100, 100, 100, 5, 10, 50, 52, 55, 58, 62, 66, 70};
  localparam int LIMIT_CYCLES = 1500000;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic              gate;
    logic [FREQ_W-1:0] freq;
    logic              active;
  } tone_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [VS_W-1:0] vertical_speed_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic gate_open_o;
  logic [FREQ_W-1:0] tone_frequency_o;
  logic tone_active_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  vario_beep_tone_controller dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state and configuration
  longint rate_q, on_lvl, off_lvl, sink_lvl;
  bit     enabled;
  longint counter, cyc_len, on_len, cur_freq;

  logic signed [VS_W-1:0] speed_queue[$];
  tone_result_t expected_tones[$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;   // no idling stretch

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // recompute tone from the ramp for speed v
  function automatic void retune(input longint v);
    int lo, hi;
    longint f, g, sf, sm, sd;
    lo = 0; hi = 0; f = 0;
    if (enabled) begin
      if (v > sink_lvl && v < off_lvl) begin
        enabled = 1'b0; cyc_len = 0; on_len = 0;
      end
    end else if (v < sink_lvl || v > on_lvl) enabled = 1'b1;
    if (!enabled) return;
    if (v < RSPD[0]) begin
      lo = 0; hi = 0;
    end else if (v >= RSPD[11]) begin
      lo = 11; hi = 11;
    end else begin
      while (lo + 2 < 12 && v >= RSPD[lo+1]) lo++;
      hi = lo + 1;
      if (v - RSPD[lo] < RSPD[hi] - RSPD[lo]) f = ((v - RSPD[lo]) << 16) / (RSPD[hi] - RSPD[lo]);
      else hi = lo;
    end
    g = 65536 - f;
    sf = RFRQ[lo] * g + RFRQ[hi] * f;
    sm = RMS[lo] * g + RMS[hi] * f;
    sd = RDTY[lo] * g + RDTY[hi] * f;
    cur_freq = (sf >> 16) & 'h7FF;
    cyc_len = ((sm * rate_q) / (1000 * 65536)) & 'h1FFFF;
    on_len = ((cyc_len * sd) / (100 * 65536)) & 'h1FFFF;
  endfunction

  function automatic tone_result_t predict_tick(input logic signed [VS_W-1:0] s);
    tone_result_t r;
    r.gate = (counter < on_len) && enabled;
    counter = (counter + 1) & 'h1FFFF;
    if (counter >= cyc_len) begin
      counter = 0;
      retune(longint'(s));
    end
    r.freq = cur_freq[FREQ_W-1:0];
    r.active = enabled;
    return r;
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 29);
  endfunction

  // driver: one tick per transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) expected_tones.push_back(predict_tick(vertical_speed_i));
        if (speed_queue.size() > 0 && !idle_now()) begin
          in_valid_i <= 1'b1;
          vertical_speed_i <= speed_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= idle_now();
    end
  end

  // monitor: compare against the oldest expectation
  always @(posedge clk_i) begin
    tone_result_t e;
    cycle_count++;
    if (out_valid_o && !out_stall_i) begin
      if (expected_tones.size() == 0) report_mismatch("result with nothing expected");
      else begin
        e = expected_tones.pop_front();
        if (gate_open_o !== e.gate)
          report_mismatch($sformatf("gate %b expected %b", gate_open_o, e.gate));
        if (tone_frequency_o !== e.freq)
          report_mismatch($sformatf("freq %0d expected %0d", tone_frequency_o, e.freq));
        if (tone_active_o !== e.active)
          report_mismatch($sformatf("active %b expected %b", tone_active_o, e.active));
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SAMPLE_RATE: rate_q = val & 'h1FFFF;
      CFG_CLIMB_ON:    on_lvl = longint'($signed(12'(val)));
      CFG_CLIMB_OFF:   off_lvl = longint'($signed(12'(val)));
      CFG_SINK:        sink_lvl = longint'($signed(12'(val)));
      default: ;
    endcase
  endtask

  task automatic drain();
    while (speed_queue.size() > 0 || in_valid_i || expected_tones.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // mostly realistic climb rates, some full-range noise
  function automatic logic signed [VS_W-1:0] rand_speed();
    int k;
    k = $urandom_range(99);
    if (k < 70) return VS_W'($urandom_range(2400) - 1200);
    if (k < 80) return VS_W'($urandom_range(20) - 10 + RSPD[$urandom_range(11)]);
    return VS_W'($urandom);
  endfunction

  initial begin
    int ph;
    logic signed [VS_W-1:0] dir [] = '{-32768, 32767, 0, -1, 1500, -1000, -1001, -300,
      -51, -50, 9, 10, 11, 5, 6, 4, 1000, 999, 600, -600, -200, 7, 100, -32768, 20};
    rate_q = 48000; on_lvl = 10; off_lvl = 5; sink_lvl = -300;
    enabled = 0; counter = 0; cyc_len = 0; on_len = 0; cur_freq = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, row edges, hysteresis band
    write_reg(CFG_SAMPLE_RATE, 8000);
    foreach (dir[i]) speed_queue.push_back(dir[i]);
    drain();
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_SAMPLE_RATE, 96000); write_reg(CFG_CLIMB_ON, -2000);
                 write_reg(CFG_CLIMB_OFF, 2000); write_reg(CFG_SINK, -2000); end
        1: begin write_reg(CFG_SAMPLE_RATE, 8000); write_reg(CFG_CLIMB_ON, 2000);
                 write_reg(CFG_CLIMB_OFF, -2000); write_reg(CFG_SINK, 2000); end
        2: begin write_reg(CFG_SAMPLE_RATE, 'h1FFFF); write_reg(CFG_CLIMB_ON, 10);
                 write_reg(CFG_CLIMB_OFF, 5); write_reg(CFG_SINK, -300); end
        3: begin write_reg(CFG_SAMPLE_RATE, 0); write_reg(CFG_UNUSED, 'h15555); end
        default: begin
          write_reg(CFG_SAMPLE_RATE, $urandom_range(200, 3000));
          write_reg(CFG_CLIMB_ON, $urandom_range(4095));
          write_reg(CFG_CLIMB_OFF, $urandom_range(4095));
          write_reg(CFG_SINK, $urandom_range(4095));
        end
      endcase
      calm = (ph == 2);
      repeat (240) speed_queue.push_back(rand_speed());
      drain();
    end
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
